/* hdl/assert_macros.svh */
// Assertion macros for the checker file of the project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* hdl/wpm_pkg.sv */
// Shared types and constants of the wildcard pattern matcher.
// No dependencies.
package wpm_pkg;

  localparam int SYMBOL_W = 16;

  localparam logic [7:0] SYM_ANY_ONE = 8'h3F;
  localparam logic [7:0] SYM_ANY_RUN = 8'h2A;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_TEXT   = 2'd2,
    MODE_END    = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e               mode;
    logic [SYMBOL_W-1:0] symbol;
  } item_t;

  typedef struct packed {
    logic matched;
    logic pattern_overflow;
  } result_t;

endpackage

/* hdl/wpm_in_if.sv */
// Input channel of the wildcard pattern matcher: valid/ready plus item fields.
// Depends on wpm_pkg.
interface wpm_in_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   mode;
  logic [wpm_pkg::SYMBOL_W-1:0] symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink (input valid, input mode, input symbol, output ready);
endinterface

/* hdl/wpm_out_if.sv */
// Result channel of the wildcard pattern matcher: valid/ready plus result fields.
// No dependencies.
interface wpm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic pattern_overflow;

  modport source (output valid, output matched, output pattern_overflow, input ready);
  modport sink (input valid, input matched, input pattern_overflow, output ready);
endinterface

/* hdl/wpm_closure.sv */
// Star closure of the position vector as a parallel-prefix OR chain.
// No dependencies.
module wpm_closure #(
  parameter int W = 33
) (
  input  logic [W-1:0] vec_i,
  input  logic [W-1:0] prop_i,
  output logic [W-1:0] closure_o
);

  localparam int LVL = (W > 1) ? $clog2(W) : 1;

  logic [W-1:0] g [LVL+1];
  logic [W-1:0] p [LVL+1];

  always_comb begin
    g[0] = vec_i;
    p[0] = prop_i;
    for (int l = 0; l < LVL; l++) begin
      g[l+1] = g[l] | (p[l] & (g[l] << (1 << l)));
      p[l+1] = p[l] & (p[l] << (1 << l));
    end
  end

  assign closure_o = g[LVL];

endmodule

/* hdl/wpm_engine.sv */
// Pattern store, position vector and per-item update of the matcher.
// Depends on wpm_pkg and wpm_closure.
module wpm_engine #(
  parameter int PATTERN_MAX = 32,
  parameter int CHAR_BITS   = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  wpm_pkg::item_t   item_i,
  output wpm_pkg::result_t res_o
);

  localparam int SYM_W = (CHAR_BITS < wpm_pkg::SYMBOL_W) ? CHAR_BITS : wpm_pkg::SYMBOL_W;
  localparam int VEC_W = PATTERN_MAX + 1;
  localparam int LEN_W = $clog2(PATTERN_MAX + 1);

  logic [SYM_W-1:0] store_q [PATTERN_MAX];
  logic [LEN_W-1:0] len_q, len_d;
  logic [VEC_W-1:0] vec_q, vec_d;
  logic             ovf_q, ovf_d;

  logic [SYM_W-1:0]       sym;
  logic [PATTERN_MAX-1:0] is_run, hit, wr_en;
  logic [VEC_W-1:0]       prop, vec_c, next_run, next_adv, len_sel;

  assign sym = item_i.symbol[SYM_W-1:0];

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pos
    logic live;
    assign live      = (LEN_W'(i) < len_q);
    assign is_run[i] = live && (store_q[i] == SYM_W'(wpm_pkg::SYM_ANY_RUN));
    assign hit[i]    = live && !is_run[i] &&
                       ((store_q[i] == SYM_W'(wpm_pkg::SYM_ANY_ONE)) || (store_q[i] == sym));
    assign wr_en[i]  = step_i && (item_i.mode == wpm_pkg::MODE_APPEND) &&
                       (len_q == LEN_W'(i));
    assign prop[i+1]     = is_run[i];
    assign next_run[i]   = vec_c[i] & is_run[i];
    assign next_adv[i+1] = vec_c[i] & hit[i];

    always_ff @(posedge clk_i) begin
      if (wr_en[i]) begin
        store_q[i] <= sym;
      end
    end
  end

  assign prop[0]                 = 1'b0;
  assign next_run[PATTERN_MAX]   = 1'b0;
  assign next_adv[0]             = 1'b0;

  for (genvar k = 0; k < VEC_W; k++) begin : g_sel
    assign len_sel[k] = (len_q == LEN_W'(k));
  end

  wpm_closure #(.W(VEC_W)) u_closure (
    .vec_i     (vec_q),
    .prop_i    (prop),
    .closure_o (vec_c)
  );

  assign res_o.matched          = |(vec_c & len_sel);
  assign res_o.pattern_overflow = ovf_q;

  always_comb begin
    len_d = len_q;
    vec_d = vec_q;
    ovf_d = ovf_q;
    if (step_i) begin
      unique case (item_i.mode)
        wpm_pkg::MODE_CLEAR: begin
          len_d = '0;
          ovf_d = 1'b0;
          vec_d = VEC_W'(1);
        end
        wpm_pkg::MODE_APPEND: begin
          if (len_q < LEN_W'(PATTERN_MAX)) begin
            len_d = len_q + LEN_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        wpm_pkg::MODE_TEXT: begin
          vec_d = next_run | next_adv;
        end
        wpm_pkg::MODE_END: begin
          vec_d = VEC_W'(1);
        end
        default: begin
          vec_d = vec_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      vec_q <= VEC_W'(1);
      ovf_q <= 1'b0;
    end else begin
      len_q <= len_d;
      vec_q <= vec_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

/* hdl/wildcard_pattern_matcher.sv */
// Top level of the wildcard pattern matcher: input register, engine, result register.
// Depends on wpm_pkg, wpm_in_if, wpm_out_if and wpm_engine.
//
// Glob matcher: '?' takes any one character, '*' any run including none. Items of mode
// clear, append and text update state; an end-of-text item yields one result. One item is
// taken every cycle unless the input stalls; a result passes the input register and then
// the result register, where it is held until taken. The input register feeds the
// engine, whose star closure is a parallel-prefix chain over the PATTERN_MAX+1 position
// bits, and the result register decouples the output. Input stalls only while an
// end-of-text item waits behind an untaken result. The pattern store sits in flip-flops;
// reset needs no clearing pass.
module wildcard_pattern_matcher #(
  parameter int PATTERN_MAX = 32,
  parameter int CHAR_BITS   = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  wpm_in_if.sink     in_i,
  wpm_out_if.source  res_o
);

  logic             s1_valid_q;
  wpm_pkg::item_t   s1_item_q;
  logic             s1_advance;
  wpm_pkg::result_t eng_res;
  logic             out_valid_q, out_valid_d;
  wpm_pkg::result_t out_res_q;
  logic             out_load;

  assign s1_advance = s1_valid_q &&
                      ((s1_item_q.mode != wpm_pkg::MODE_END) || !out_valid_q || res_o.ready);
  assign in_i.ready = !s1_valid_q || s1_advance;
  assign out_load   = s1_advance && (s1_item_q.mode == wpm_pkg::MODE_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q.mode   <= wpm_pkg::mode_e'(in_i.mode);
      s1_item_q.symbol <= in_i.symbol;
    end
  end

  wpm_engine #(
    .PATTERN_MAX (PATTERN_MAX),
    .CHAR_BITS   (CHAR_BITS)
  ) u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_advance),
    .item_i (s1_item_q),
    .res_o  (eng_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q <= eng_res;
    end
  end

  assign res_o.valid            = out_valid_q;
  assign res_o.matched          = out_res_q.matched;
  assign res_o.pattern_overflow = out_res_q.pattern_overflow;

endmodule

/* hdl/wpm_checker.sv */
// Port-level checks of the wildcard pattern matcher and their binding.
// Depends on assert_macros.svh, wpm_pkg and wildcard_pattern_matcher.
`include "assert_macros.svh"

module wpm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic [1:0] in_mode_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       out_matched_i,
  input logic       out_overflow_i
);

  logic in_xfer;
  assign in_xfer = in_valid_i && in_ready_i;

  // hold the result while the transfer is stalled
  `ASSERT_NEXT(a_res_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_matched_i) && $stable(out_overflow_i))

  // a fresh result comes from an end-of-text transfer through the input and result registers
  `ASSERT_IMPLY(a_res_source, clk_i, rst_ni, $rose(out_valid_i), $past(in_xfer && (in_mode_i == wpm_pkg::MODE_END), 2))

  // input stalls only behind a result that is not taken
  `ASSERT_IMPLY(a_stall_cause, clk_i, rst_ni, !in_ready_i, out_valid_i && !out_ready_i)

endmodule

bind wildcard_pattern_matcher wpm_checker u_wpm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_i.valid),
  .in_ready_i     (in_i.ready),
  .in_mode_i      (in_i.mode),
  .out_valid_i    (res_o.valid),
  .out_ready_i    (res_o.ready),
  .out_matched_i  (res_o.matched),
  .out_overflow_i (res_o.pattern_overflow)
);

/* tb/wpm_match_checker.sv */
// Checker for the wildcard pattern matcher: watches both channels, predicts each result
// from its own copy of the pattern store and position vector, and counts mismatches.
// Depends on wpm_pkg, wpm_in_if and wpm_out_if.
module wpm_match_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  wpm_in_if           in_i,
  wpm_out_if          res_i,
  output int unsigned mismatch_count_o,
  output int unsigned results_pending_o,
  output int unsigned results_seen_o,
  output int unsigned matches_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import wpm_pkg::*;

  localparam int PATTERN_MAX = 32;
  localparam int MAX_REPORTS = 10;
  localparam logic [SYMBOL_W-1:0] CH_ONE = {{(SYMBOL_W-8){1'b0}}, SYM_ANY_ONE};
  localparam logic [SYMBOL_W-1:0] CH_RUN = {{(SYMBOL_W-8){1'b0}}, SYM_ANY_RUN};

  logic [SYMBOL_W-1:0]  pattern_chars [PATTERN_MAX];
  int unsigned          pattern_len;
  logic [PATTERN_MAX:0] live_positions;
  logic                 chars_dropped;
  result_t              awaited_results [$];
  int unsigned          mismatch_total;
  int unsigned          result_total;
  int unsigned          match_total;

  function automatic logic [PATTERN_MAX:0] close_stars(input logic [PATTERN_MAX:0] v);
    logic [PATTERN_MAX:0] c;
    c = v;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < pattern_len && c[i] && pattern_chars[i] == CH_RUN) begin
        c[i+1] = 1'b1;
      end
    end
    return c;
  endfunction

  function automatic logic [PATTERN_MAX:0] advance_text(input logic [SYMBOL_W-1:0] ch);
    logic [PATTERN_MAX:0] cur;
    logic [PATTERN_MAX:0] nxt;
    cur = close_stars(live_positions);
    nxt = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i < pattern_len && cur[i]) begin
        if (pattern_chars[i] == CH_RUN) begin
          nxt[i] = 1'b1;
        end else if (pattern_chars[i] == CH_ONE || pattern_chars[i] == ch) begin
          nxt[i+1] = 1'b1;
        end
      end
    end
    return nxt;
  endfunction

  task automatic note_failure(input string msg);
    mismatch_total++;
    if (mismatch_total <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t              want;
    logic [PATTERN_MAX:0] closed;
    if (!rst_ni) begin
      for (int i = 0; i < PATTERN_MAX; i++) pattern_chars[i] = '0;
      pattern_len    = 0;
      live_positions = {{PATTERN_MAX{1'b0}}, 1'b1};
      chars_dropped  = 1'b0;
      awaited_results.delete();
      mismatch_total = 0;
      result_total   = 0;
      match_total    = 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        result_total++;
        if (res_i.matched === 1'b1) match_total++;
        if (awaited_results.size() == 0) begin
          note_failure($sformatf("unexpected result matched=%0b overflow=%0b",
                                 res_i.matched, res_i.pattern_overflow));
        end else begin
          want = awaited_results.pop_front();
          if (res_i.matched !== want.matched ||
              res_i.pattern_overflow !== want.pattern_overflow) begin
            note_failure($sformatf(
              "result %0d: expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
              result_total, want.matched, want.pattern_overflow,
              res_i.matched, res_i.pattern_overflow));
          end
        end
      end
      if (in_i.valid && in_i.ready) begin
        case (mode_e'(in_i.mode))
          MODE_CLEAR: begin
            pattern_len    = 0;
            chars_dropped  = 1'b0;
            live_positions = {{PATTERN_MAX{1'b0}}, 1'b1};
          end
          MODE_APPEND: begin
            if (pattern_len < PATTERN_MAX) begin
              pattern_chars[pattern_len] = in_i.symbol;
              pattern_len++;
            end else begin
              chars_dropped = 1'b1;
            end
          end
          MODE_TEXT: begin
            live_positions = advance_text(in_i.symbol);
          end
          default: begin
            closed = close_stars(live_positions);
            want.matched          = closed[pattern_len];
            want.pattern_overflow = chars_dropped;
            awaited_results.insert(awaited_results.size(), want);
            live_positions = {{PATTERN_MAX{1'b0}}, 1'b1};
          end
        endcase
      end
    end
    mismatch_count_o  <= mismatch_total;
    results_pending_o <= awaited_results.size();
    results_seen_o    <= result_total;
    matches_seen_o    <= match_total;
  end

endmodule

/* tb/wildcard_pattern_matcher_tb.sv */
// Top of the wildcard pattern matcher testbench: clock, reset, stimulus and verdict.
// Depends on wpm_pkg, wpm_in_if, wpm_out_if, wpm_match_checker and the block itself.
module wildcard_pattern_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wpm_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int PHASE_ITEMS     = 355;
  localparam int STORE_DEPTH     = 32;
  localparam logic [SYMBOL_W-1:0] CH_ONE = {{(SYMBOL_W-8){1'b0}}, SYM_ANY_ONE};
  localparam logic [SYMBOL_W-1:0] CH_RUN = {{(SYMBOL_W-8){1'b0}}, SYM_ANY_RUN};

  logic        clk_i  = 1'b0;
  logic        rst_ni = 1'b0;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned results_seen;
  int unsigned matches_seen;
  int unsigned send_idle_pct = 17;
  int unsigned recv_idle_pct = 64;
  bit          hold_req      = 1'b0;
  int unsigned items_sent    = 0;
  int unsigned cycles        = 0;

  wpm_in_if  in_ch ();
  wpm_out_if res_ch ();

  wildcard_pattern_matcher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .res_o  (res_ch)
  );

  wpm_match_checker chk (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_i              (in_ch),
    .res_i             (res_ch),
    .mismatch_count_o  (mismatches),
    .results_pending_o (pending),
    .results_seen_o    (results_seen),
    .matches_seen_o    (matches_seen)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("wildcard_pattern_matcher_tb failed");
      $finish;
    end
  end

  // Receiver: random back-pressure, with a long hold-off on request.
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end
      res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [SYMBOL_W-1:0] pick_symbol();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return SYMBOL_W'(16'h0061 + $urandom_range(2));
    if (pick < 85) return SYMBOL_W'($urandom);
    if (pick < 90) return {8'($urandom_range(1, 255)), SYM_ANY_ONE};
    if (pick < 95) return {8'($urandom_range(1, 255)), SYM_ANY_RUN};
    return (pick < 98) ? '1 : '0;
  endfunction

  task automatic send_item(input mode_e m, input logic [SYMBOL_W-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.mode   <= m;
    in_ch.symbol <= s;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Load a random glob, then feed texts built to fit it, some of them broken; some runs send only random items.
  task automatic run_sequence();
    logic [SYMBOL_W-1:0] glob [$];
    logic [SYMBOL_W-1:0] text_q [$];
    int unsigned         len;
    int unsigned         pick;
    int unsigned         n_texts;
    int unsigned         pos;
    pick = $urandom_range(99);
    if (pick < 6) begin
      repeat ($urandom_range(3, 8)) send_item(mode_e'($urandom_range(3)), SYMBOL_W'($urandom));
      return;
    end
    if (pick < 88) len = $urandom_range(0, 8);
    else if (pick < 97) len = $urandom_range(9, STORE_DEPTH);
    else len = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 4);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      glob.insert(glob.size(), pick < 30 ? CH_RUN : (pick < 50 ? CH_ONE : pick_symbol()));
    end
    send_item(MODE_CLEAR, SYMBOL_W'($urandom));
    foreach (glob[i]) send_item(MODE_APPEND, glob[i]);
    n_texts = $urandom_range(1, 4);
    for (int t = 0; t < n_texts; t++) begin
      text_q.delete();
      for (int i = 0; i < glob.size() && i < STORE_DEPTH; i++) begin
        if (glob[i] == CH_RUN) begin
          repeat ($urandom_range(3)) text_q.insert(text_q.size(), pick_symbol());
        end else if (glob[i] == CH_ONE) begin
          text_q.insert(text_q.size(), pick_symbol());
        end else begin
          text_q.insert(text_q.size(), glob[i]);
        end
      end
      if ($urandom_range(99) < 25) begin
        pos = (text_q.size() == 0) ? 0 : $urandom_range(text_q.size() - 1);
        case ($urandom_range(2))
          0: if (text_q.size() != 0) text_q[pos] = pick_symbol();
          1: if (text_q.size() != 0) text_q.delete(pos);
          default: text_q.insert(pos, pick_symbol());
        endcase
      end
      foreach (text_q[i]) begin
        pick = $urandom_range(99);
        if (pick < 3) send_item(MODE_APPEND, pick_symbol());
        else if (pick < 5) send_item(MODE_CLEAR, SYMBOL_W'($urandom));
        send_item(MODE_TEXT, text_q[i]);
      end
      send_item(MODE_END, SYMBOL_W'($urandom));
    end
  endtask

  // Hold off the receiver while ends keep arriving, so the input stalls.
  task automatic run_pressure();
    hold_req = 1'b1;
    repeat (12) begin
      send_item(MODE_TEXT, pick_symbol());
      send_item(MODE_END, SYMBOL_W'($urandom));
    end
    drain_results();
  endtask

  task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned target;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target = items_sent + PHASE_ITEMS;
    while (items_sent < target) run_sequence();
    drain_results();
  endtask

  initial begin
    in_ch.valid  <= 1'b0;
    in_ch.mode   <= MODE_CLEAR;
    in_ch.symbol <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty pattern against empty text, then against one character
    send_item(MODE_END, '0);
    send_item(MODE_TEXT, '1);
    send_item(MODE_END, '1);
    // question mark needs one character
    send_item(MODE_APPEND, CH_ONE);
    send_item(MODE_END, '0);
    send_item(MODE_TEXT, '0);
    send_item(MODE_END, '0);
    // trailing stars match empty text
    send_item(MODE_CLEAR, '1);
    send_item(MODE_APPEND, CH_RUN);
    send_item(MODE_APPEND, CH_RUN);
    send_item(MODE_END, '0);
    // append during a text keeps the vector
    send_item(MODE_TEXT, {8'h01, SYM_ANY_ONE});
    send_item(MODE_APPEND, '1);
    send_item(MODE_TEXT, '1);
    send_item(MODE_END, '0);
    // text that runs past the pattern's end does not match
    send_item(MODE_APPEND, {8'h01, SYM_ANY_RUN});
    send_item(MODE_TEXT, CH_RUN);
    send_item(MODE_TEXT, '1);
    send_item(MODE_TEXT, {8'h01, SYM_ANY_RUN});
    send_item(MODE_TEXT, '0);
    send_item(MODE_END, '0);
    drain_results();

    send_idle_pct = 17;
    recv_idle_pct = 64;
    run_pressure();
    run_phase(17, 64);
    run_phase(64, 17);
    run_pressure();
    run_phase(0, 0);

    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    $display("Sent %0d items (clear, append, text, end) over three idling phases", items_sent);
    $display("Checked %0d results, %0d of them matches, with two receiver hold-offs",
             results_seen, matches_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("wildcard_pattern_matcher_tb passed");
    end else begin
      $display("wildcard_pattern_matcher_tb failed");
    end
    $finish;
  end

endmodule
